/* design/ubcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubcw_pkg: shared types and constants for the uniform border crop window
// frame size register defaults, field widths, packing of stream items
// ----------------------------------------------------------------------------
package ubcw_pkg;

    // configuration register width and defaults
    localparam int CFG_W            = 13;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int MAX_DIM_DEF      = 4096;

    // pixel and result field widths
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int IN_TDATA_W   = PIX_W;
    localparam int CROP_POS_W   = 12;
    localparam int CROP_DIM_W   = 13;
    localparam int RESULT_W     = 2 * CROP_POS_W + 2 * CROP_DIM_W + 2;
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // configuration register index
    localparam int REG_IDX_W = 1;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // one pixel, blue in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // one crop result, crop_x in the lowest bits
    typedef struct packed {
        logic                  all_background;
        logic                  border_found;
        logic [CROP_DIM_W-1:0] crop_height;
        logic [CROP_DIM_W-1:0] crop_width;
        logic [CROP_POS_W-1:0] crop_y;
        logic [CROP_POS_W-1:0] crop_x;
    } t_result;

endpackage

/* design/uniform_border_crop_window_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_border_crop_window_core: automatic crop of a uniform frame border
// finds the bounding box of non-background pixels and checks the outer edges
// ----------------------------------------------------------------------------
// usage
// - pixels enter on the s_axis channel in raster order, one item per pixel;
//   the first pixel of each frame sets the background color
// - frame size comes from the config port (index 0 width, 1 height); values
//   are clamped to 1..MAX_DIM and should be written while the block is idle
// - on the last pixel of a frame one crop item leaves on m_axis: the full
//   frame if any outer edge holds a non-background pixel, else the content
//   bounding box; an all-background frame gives a zero-size window
// - throughput: one pixel per clock across frame boundaries, except that a
//   closing pixel waits while the result register holds an unaccepted item
// - the last pixel of a frame passes the input register, then per-pixel
//   compare/update into the result register
// - receiver stall: the result register holds the crop item; pixels keep
//   flowing until the last pixel of the next frame needs that register
// - reset (i_rst_n low, synchronous): frame size returns to 640 x 480,
//   counters and bounding box clear, both stages empty
// ----------------------------------------------------------------------------
module uniform_border_crop_window_core #(
    parameter int MAX_DIM = ubcw_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [ubcw_pkg::REG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ubcw_pkg::CFG_W-1:0]       i_cfg_data,
    // pixel input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields from bit 0: blue[7:0], green[15:8], red[23:16]
    input  logic [ubcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // crop result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // fields from bit 0: crop_x[11:0], crop_y[23:12], crop_width[36:24],
    // crop_height[49:37], border_found[50], all_background[51], zero fill
    output logic [ubcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // counter width and widths used for clamping and result extension
    localparam int DIM_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int CW    = (ubcw_pkg::CFG_W > DIM_W + 1) ? ubcw_pkg::CFG_W : DIM_W + 1;
    localparam int EW    = (DIM_W + 1 > ubcw_pkg::CROP_DIM_W) ? DIM_W + 1
                                                               : ubcw_pkg::CROP_DIM_W;
    localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);

    // configuration registers
    logic [ubcw_pkg::CFG_W-1:0] r_frame_width;
    logic [ubcw_pkg::CFG_W-1:0] r_frame_height;

    // input register stage
    logic              r_s1_valid;
    ubcw_pkg::t_pixel  r_pix;

    // per-frame state
    ubcw_pkg::t_pixel  r_bg,        n_bg;
    logic [DIM_W-1:0]  r_col,       n_col;
    logic [DIM_W-1:0]  r_row,       n_row;
    logic [DIM_W-1:0]  r_min_col,   n_min_col;
    logic [DIM_W-1:0]  r_max_col,   n_max_col;
    logic [DIM_W-1:0]  r_min_row,   n_min_row;
    logic [DIM_W-1:0]  r_max_row,   n_max_row;
    logic              r_edges_ok,  n_edges_ok;
    logic              r_content,   n_content;

    // result register
    logic              r_out_valid;
    ubcw_pkg::t_result r_result,    n_result;

    // clamped frame size and last column / row index
    logic [CW-1:0]     w_ext, h_ext, w_clamp, h_clamp;
    logic [DIM_W-1:0]  last_col, last_row_idx;

    // per-pixel decisions
    logic              first_pix, differ, row_end, last_row, emit;
    logic              out_free, s1_go, s1_fire;
    logic [DIM_W:0]    box_w, box_h;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ubcw_pkg::CFG_W'(ubcw_pkg::FRAME_WIDTH_RST);
            r_frame_height <= ubcw_pkg::CFG_W'(ubcw_pkg::FRAME_HEIGHT_RST);
        end else if (i_cfg_we) begin
            case (ubcw_pkg::t_reg_idx'(i_cfg_addr))
                ubcw_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                ubcw_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to 1..MAX_DIM; zero acts as one
    always_comb begin
        w_ext = CW'(r_frame_width);
        h_ext = CW'(r_frame_height);
        if (w_ext == '0) begin
            w_clamp = CW'(1);
        end else if (w_ext > MAX_DIM_C) begin
            w_clamp = MAX_DIM_C;
        end else begin
            w_clamp = w_ext;
        end
        if (h_ext == '0) begin
            h_clamp = CW'(1);
        end else if (h_ext > MAX_DIM_C) begin
            h_clamp = MAX_DIM_C;
        end else begin
            h_clamp = h_ext;
        end
    end

    assign last_col     = DIM_W'(w_clamp - CW'(1));
    assign last_row_idx = DIM_W'(h_clamp - CW'(1));

    // ------------------------------------------------------------------
    // handshake: the input stage only waits when its pixel closes a frame
    // and the result register is still occupied
    // ------------------------------------------------------------------
    assign row_end  = (r_col >= last_col);
    assign last_row = (r_row >= last_row_idx);
    assign emit     = row_end && last_row;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = !emit || out_free;
    assign s1_fire       = r_s1_valid && s1_go;
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pix <= ubcw_pkg::t_pixel'(s_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // per-pixel update of background, counters, edge check and box
    // ------------------------------------------------------------------
    always_comb begin
        first_pix = (r_col == '0) && (r_row == '0);
        n_bg      = first_pix ? r_pix : r_bg;
        differ    = (r_pix != n_bg);

        n_edges_ok = r_edges_ok;
        n_min_col  = r_min_col;
        n_max_col  = r_max_col;
        n_min_row  = r_min_row;
        n_max_row  = r_max_row;
        n_content  = r_content;
        if (differ) begin
            // any hit on the first/last row or column spoils the border
            if ((r_row == '0) || last_row || (r_col == '0) || row_end) begin
                n_edges_ok = 1'b0;
            end
            if (r_col < r_min_col) n_min_col = r_col;
            if (r_col > r_max_col) n_max_col = r_col;
            if (r_row < r_min_row) n_min_row = r_row;
            if (r_row > r_max_row) n_max_row = r_row;
            n_content = 1'b1;
        end

        // raster position; a shrunk size ends the row / frame at once
        if (!row_end) begin
            n_col = r_col + DIM_W'(1);
            n_row = r_row;
        end else if (!last_row) begin
            n_col = '0;
            n_row = r_row + DIM_W'(1);
        end else begin
            n_col = '0;
            n_row = '0;
        end
    end

    // crop window from the state including the closing pixel
    always_comb begin
        box_w = {1'b0, n_max_col} - {1'b0, n_min_col} + (DIM_W + 1)'(1);
        box_h = {1'b0, n_max_row} - {1'b0, n_min_row} + (DIM_W + 1)'(1);
        if (!n_edges_ok) begin
            n_result.crop_x         = '0;
            n_result.crop_y         = '0;
            n_result.crop_width     = ubcw_pkg::CROP_DIM_W'(EW'(w_clamp));
            n_result.crop_height    = ubcw_pkg::CROP_DIM_W'(EW'(h_clamp));
            n_result.border_found   = 1'b0;
            n_result.all_background = 1'b0;
        end else if (!n_content) begin
            n_result.crop_x         = '0;
            n_result.crop_y         = '0;
            n_result.crop_width     = '0;
            n_result.crop_height    = '0;
            n_result.border_found   = 1'b1;
            n_result.all_background = 1'b1;
        end else begin
            n_result.crop_x         = ubcw_pkg::CROP_POS_W'(EW'(n_min_col));
            n_result.crop_y         = ubcw_pkg::CROP_POS_W'(EW'(n_min_row));
            n_result.crop_width     = ubcw_pkg::CROP_DIM_W'(EW'(box_w));
            n_result.crop_height    = ubcw_pkg::CROP_DIM_W'(EW'(box_h));
            n_result.border_found   = 1'b1;
            n_result.all_background = 1'b0;
        end
    end

    // per-frame state registers; cleared after the closing pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg       <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_min_col  <= '1;
            r_max_col  <= '0;
            r_min_row  <= '1;
            r_max_row  <= '0;
            r_edges_ok <= 1'b1;
            r_content  <= 1'b0;
        end else if (s1_fire) begin
            r_col <= n_col;
            r_row <= n_row;
            if (emit) begin
                r_bg       <= '0;
                r_min_col  <= '1;
                r_max_col  <= '0;
                r_min_row  <= '1;
                r_max_row  <= '0;
                r_edges_ok <= 1'b1;
                r_content  <= 1'b0;
            end else begin
                r_bg       <= n_bg;
                r_min_col  <= n_min_col;
                r_max_col  <= n_max_col;
                r_min_row  <= n_min_row;
                r_max_row  <= n_max_row;
                r_edges_ok <= n_edges_ok;
                r_content  <= n_content;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ubcw_pkg::OUT_TDATA_W'(r_result);

`ifndef NO_ASSERTIONS
    // a closing pixel always lands a crop item in the result register
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && emit) |=> m_axis_tvalid)
        else $error("crop item missing after frame end");

    // the frame restarts at the origin with no content after a crop item
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && emit) |=> (r_col == '0 && r_row == '0 && !r_content && r_edges_ok))
        else $error("frame state not cleared after frame end");

    // no content means the bounding box is still at its cleared value
    a_box_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_content |-> (r_min_col == '1 && r_max_col == '0 &&
                        r_min_row == '1 && r_max_row == '0))
        else $error("bounding box moved without content");

    // a stalled crop item blocks the input only on a closing pixel
    a_stall_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s_axis_tready) |-> (emit && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending crop item");
`endif

endmodule

/* test/uniform_border_crop_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_border_crop_window_checker: crop result scoreboard
// follows frame size writes and pixel items, predicts the crop item of each
// frame and compares every item on the output channel field by field
// ----------------------------------------------------------------------------
module uniform_border_crop_window_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ubcw_pkg::REG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ubcw_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // fields from bit 0: blue, green, red
    input  logic [ubcw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // fields from bit 0: crop_x, crop_y, crop_width, crop_height,
    // border_found, all_background, zero fill
    input  logic [ubcw_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_mismatches,
    output int                               o_pending
);

    import ubcw_pkg::*;

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [PIX_W-1:0]      bg_color;
    logic [CROP_POS_W-1:0] col_cnt;
    logic [CROP_POS_W-1:0] row_cnt;
    logic [CROP_POS_W-1:0] min_col;
    logic [CROP_POS_W-1:0] max_col;
    logic [CROP_POS_W-1:0] min_row;
    logic [CROP_POS_W-1:0] max_row;
    logic                  edges_clean;
    logic                  content_seen;
    t_result               pending_crops[$];
    int                    mismatches = 0;

    assign o_mismatches = mismatches;

    // size registers are clamped to 1..MAX_DIM when used
    function automatic int frame_dim(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    task automatic clear_frame();
        bg_color     = '0;
        col_cnt      = '0;
        row_cnt      = '0;
        min_col      = '1;
        max_col      = '0;
        min_row      = '1;
        max_row      = '0;
        edges_clean  = 1'b1;
        content_seen = 1'b0;
    endtask

    task automatic track_pixel(t_pixel px);
        int      w;
        int      h;
        int      col;
        int      row;
        logic    row_end;
        logic    last_row;
        t_result crop;
        w        = frame_dim(width_reg);
        h        = frame_dim(height_reg);
        col      = int'(col_cnt);
        row      = int'(row_cnt);
        row_end  = col >= w - 1;
        last_row = row >= h - 1;
        if (col == 0 && row == 0) bg_color = px;
        if (px != bg_color) begin
            if (row == 0 || last_row || col == 0 || row_end) edges_clean = 1'b0;
            if (col < int'(min_col)) min_col = CROP_POS_W'(col);
            if (col > int'(max_col)) max_col = CROP_POS_W'(col);
            if (row < int'(min_row)) min_row = CROP_POS_W'(row);
            if (row > int'(max_row)) max_row = CROP_POS_W'(row);
            content_seen = 1'b1;
        end
        if (!row_end) begin
            col_cnt = CROP_POS_W'(col + 1);
        end else begin
            col_cnt = '0;
            if (!last_row) begin
                row_cnt = CROP_POS_W'(row + 1);
            end else begin
                crop = '0;
                if (!edges_clean) begin
                    crop.crop_width  = CROP_DIM_W'(w);
                    crop.crop_height = CROP_DIM_W'(h);
                end else if (!content_seen) begin
                    crop.border_found   = 1'b1;
                    crop.all_background = 1'b1;
                end else begin
                    crop.crop_x       = min_col;
                    crop.crop_y       = min_row;
                    crop.crop_width   = CROP_DIM_W'(int'(max_col) - int'(min_col) + 1);
                    crop.crop_height  = CROP_DIM_W'(int'(max_row) - int'(min_row) + 1);
                    crop.border_found = 1'b1;
                end
                pending_crops.insert(pending_crops.size(), crop);
                clear_frame();
            end
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_crop(t_result got);
        t_result want;
        if (pending_crops.size() == 0) begin
            $display("%0t: unexpected crop item, expected none, actual %h", $time, got);
            mismatches++;
        end else begin
            want = pending_crops.pop_front();
            check_field("crop_x", int'(want.crop_x), int'(got.crop_x));
            check_field("crop_y", int'(want.crop_y), int'(got.crop_y));
            check_field("crop_width", int'(want.crop_width), int'(got.crop_width));
            check_field("crop_height", int'(want.crop_height), int'(got.crop_height));
            check_field("border_found", int'(want.border_found), int'(got.border_found));
            check_field("all_background", int'(want.all_background),
                        int'(got.all_background));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = CFG_W'(FRAME_WIDTH_RST);
            height_reg = CFG_W'(FRAME_HEIGHT_RST);
            clear_frame();
            pending_crops.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_FRAME_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_addr == REG_FRAME_HEIGHT) height_reg = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) compare_crop(t_result'(i_m_tdata[RESULT_W-1:0]));
            if (i_s_tvalid && i_s_tready) track_pixel(t_pixel'(i_s_tdata));
        end
        o_pending <= pending_crops.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for uniform_border_crop_window_core
// streams frames of pixels (plain background, inner content boxes, boxes that
// touch the edges, noise) under several frame sizes and idle patterns; the
// checker predicts every crop item and counts mismatches
// ----------------------------------------------------------------------------
module testbench;

    import ubcw_pkg::*;

    // drain time for the pipeline before config writes
    localparam int SETTLE_CYCLES = 4;
    // random part: pixel items and frames per idle phase
    localparam int PHASE_PIXELS  = 290;
    localparam int PHASE_FRAMES  = 6;

    typedef enum int {FILL_PLAIN, FILL_BOX, FILL_NOISE} t_fill;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0]   i_cfg_addr    = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // fields from bit 0: blue[7:0], green[15:8], red[23:16]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // fields from bit 0: crop_x, crop_y, crop_width, crop_height,
    // border_found, all_background, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int crops_outstanding;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int pixels_sent   = 0;
    int frames_sent   = 0;

    always #4 i_clk = ~i_clk;

    uniform_border_crop_window_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    uniform_border_crop_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (crops_outstanding)
    );

    // receiver side: tready drops at random according to the current phase
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("** uniform_border_crop_window_core: FAILED **");
        $finish;
    end

    // some color other than the background: either fully random or one
    // flipped bit, so single-bit compare faults show up
    function automatic t_pixel other_color(t_pixel bg);
        t_pixel px;
        do begin
            if ($urandom_range(1) == 1) px = PIX_W'($urandom);
            else px = bg ^ (24'h1 << $urandom_range(PIX_W - 1));
        end while (px == bg);
        return px;
    endfunction

    // frame dimension, mostly small so that results come often
    function automatic int pick_dim();
        int r;
        r = $urandom_range(9);
        if (r < 6) return $urandom_range(1, 5);
        if (r < 9) return $urandom_range(6, 12);
        return $urandom_range(13, 24);
    endfunction

    // one pixel item; valid only drops when a gap is wanted, so back-to-back
    // items never lower and raise valid in the same step
    task automatic push_pixel(t_pixel px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // stop sending, wait for every predicted crop item, then let the
    // pipeline drain before touching the size registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (crops_outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both size registers, one write per clock
    task automatic set_size(logic [CFG_W-1:0] wv, logic [CFG_W-1:0] hv);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_FRAME_WIDTH;
        i_cfg_data <= wv;
        @(posedge i_clk);
        i_cfg_addr <= REG_FRAME_HEIGHT;
        i_cfg_data <= hv;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one whole frame in raster order; inside the box a pixel differs from
    // the background with the given density, the first pixel never does
    task automatic send_frame(int w, int h, t_pixel bg, t_fill fill,
                              int x0, int y0, int x1, int y1, int density);
        t_pixel px;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                px = bg;
                if (fill == FILL_NOISE) begin
                    px = PIX_W'($urandom);
                end else if (fill == FILL_BOX && !(r == 0 && c == 0) &&
                             c >= x0 && c <= x1 && r >= y0 && r <= y1 &&
                             $urandom_range(99) < density) begin
                    px = other_color(bg);
                end
                push_pixel(px);
            end
        end
        frames_sent++;
    endtask

    // random frame shape: inner box (true border), box anywhere (usually
    // breaks an edge), plain background or noise
    task automatic random_frame(int w, int h);
        int     r;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        int     saved_idle;
        int     saved_stall;
        t_fill  fill;
        t_pixel bg;
        bg          = PIX_W'($urandom);
        saved_idle  = idle_pct;
        saved_stall = stall_pct;
        // now and then a frame with no idling at all
        if ($urandom_range(5) == 0) begin
            idle_pct  = 0;
            stall_pct = 0;
        end
        r    = $urandom_range(99);
        fill = FILL_BOX;
        if (r < 15) begin
            fill = FILL_PLAIN;
        end else if (r >= 85) begin
            fill = FILL_NOISE;
        end
        if (r < 60 && w >= 3 && h >= 3) begin
            x0 = $urandom_range(1, w - 2);
            x1 = $urandom_range(x0, w - 2);
            y0 = $urandom_range(1, h - 2);
            y1 = $urandom_range(y0, h - 2);
        end else begin
            x0 = $urandom_range(0, w - 1);
            x1 = $urandom_range(x0, w - 1);
            y0 = $urandom_range(0, h - 1);
            y1 = $urandom_range(y0, h - 1);
        end
        send_frame(w, h, bg, fill, x0, y0, x1, y1, $urandom_range(20, 100));
        idle_pct  = saved_idle;
        stall_pct = saved_stall;
    endtask

    initial begin
        int     w;
        int     h;
        int     start_pixels;
        int     start_frames;
        t_pixel bg;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, no idling ----
        // zero sizes clamp to a single-pixel frame: always all background
        set_size(0, 0);
        send_frame(1, 1, 24'h000000, FILL_PLAIN, 0, 0, 0, 0, 0);
        send_frame(1, 1, 24'h000000, FILL_NOISE, 0, 0, 0, 0, 0);
        settle();
        // centre pixel on white background gives a one-pixel window
        set_size(3, 3);
        send_frame(3, 3, 24'hFFFFFF, FILL_BOX, 1, 1, 1, 1, 100);
        // top right corner differs: full frame, no border
        send_frame(3, 3, PIX_W'($urandom), FILL_BOX, 2, 0, 2, 0, 100);
        // whole background frame with a real size
        send_frame(3, 3, 24'h000000, FILL_PLAIN, 0, 0, 0, 0, 0);
        settle();
        // size shrinks under a frame in progress: column and row counts are
        // already past the new last column and row, so the next pixel ends it
        set_size(4, 4);
        bg = PIX_W'($urandom);
        for (int i = 0; i < 11; i++) begin
            push_pixel(i == 5 ? other_color(bg) : bg);
        end
        settle();
        set_size(2, 2);
        push_pixel(bg);
        frames_sent++;
        settle();

        // sizes above the maximum clamp to it: a width or height of 4097
        // keeps the row or frame open for a few pixels, then a small size
        // closes it at once
        set_size(4097, 1);
        for (int i = 0; i < 6; i++) begin
            push_pixel(i == 2 ? other_color(bg) : bg);
        end
        settle();
        set_size(6, 1);
        push_pixel(bg);
        frames_sent++;
        settle();
        set_size(1, 4097);
        for (int i = 0; i < 6; i++) begin
            push_pixel(i == 3 ? other_color(bg) : bg);
        end
        settle();
        set_size(1, 6);
        push_pixel(bg);
        frames_sent++;
        settle();

        // ---- random part, one phase per idle pattern ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            start_pixels = pixels_sent;
            start_frames = frames_sent;
            while (pixels_sent - start_pixels < PHASE_PIXELS ||
                   frames_sent - start_frames < PHASE_FRAMES) begin
                w = pick_dim();
                h = pick_dim();
                settle();
                // a size of one is sometimes written as zero
                set_size(CFG_W'((w == 1 && $urandom_range(1) == 1) ? 0 : w),
                         CFG_W'((h == 1 && $urandom_range(1) == 1) ? 0 : h));
                // several frames back to back under one setting
                repeat ($urandom_range(1, 4)) random_frame(w, h);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("** uniform_border_crop_window_core: PASSED **");
        end else begin
            $display("** uniform_border_crop_window_core: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ubcw_pkg.sv
design/uniform_border_crop_window_core.sv
test/uniform_border_crop_window_checker.sv
test/testbench.sv
